>>> rtl/cpc_pkg.sv
// Shared constants and widths for the color period classifier.
`timescale 1ns / 1ps
package cpc_pkg;
  localparam int PERIOD_W = 16;
  localparam int RELOAD_W = 16;
  localparam int FREQ_CFG_W = 24;
  localparam int CLK_W = 28;
  localparam int US_W = 36;
  localparam int SCALED_W = 36;
  localparam int LEVEL_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [19:0] US_SCALE = 20'd1000000;
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [7:0] SAT_LEVEL = 8'd250;
  localparam logic [7:0] MARGIN = 8'd20;

  localparam logic [CFG_IDX_W-1:0] REG_RED_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 3'd4;
endpackage

>>> rtl/cpc_if.sv
// Valid/ready channel interfaces for period words and level words.
`timescale 1ns / 1ps
interface cpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_period;
  logic [15:0] green_period;
  modport source (output valid, red_period, green_period, input ready);
  modport sink (input valid, red_period, green_period, output ready);
endinterface

interface cpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic       is_red;
  logic       is_green;
  modport source (output valid, red_level, green_level, is_red, is_green, input ready);
  modport sink (input valid, red_level, green_level, is_red, is_green, output ready);
endinterface

>>> rtl/color_period_classifier_top.sv
// Top level of the color period classifier: registers, two lanes, decision.
`timescale 1ns / 1ps
// Takes one word of red and green pulse periods per cycle, unless stalled, and returns
// one word of calibrated 8-bit levels and a red/green decision per input word, in order.
// Each color lane has a scaling register, three bit-per-stage dividers (microsecond,
// frequency, level) and a second scaling register before the level divider; the output
// register follows. The whole pipeline holds while the output word waits, so in_ch.ready
// follows out_ch.ready when the output register is full. The user must write calibration
// registers through the cfg_ port only while the block is idle; the block does not enforce it.
module color_period_classifier_top #(
  parameter int TIMER_CLOCK_HZ = 42000000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpc_in_if.sink                         in_ch,
  cpc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cpc_pkg::*;

  logic [FREQ_CFG_W-1:0] red_low_r, red_high_r, green_low_r, green_high_r;
  logic [RELOAD_W-1:0]   reload_r;
  logic                  adv;
  logic                  r_vld, g_vld;
  logic [LEVEL_W-1:0]    r_lvl, g_lvl;
  logic [LEVEL_W-1:0]    diff;
  logic                  decide;
  logic                  out_vld_r;
  logic [LEVEL_W-1:0]    red_level_r, green_level_r;
  logic                  is_red_r, is_green_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_low_r    <= FREQ_CFG_W'(599);
      red_high_r   <= FREQ_CFG_W'(2441);
      green_low_r  <= FREQ_CFG_W'(566);
      green_high_r <= FREQ_CFG_W'(1327);
      reload_r     <= RELOAD_W'(20000);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RED_LOW:    red_low_r    <= cfg_wdata;
        REG_RED_HIGH:   red_high_r   <= cfg_wdata;
        REG_GREEN_LOW:  green_low_r  <= cfg_wdata;
        REG_GREEN_HIGH: green_high_r <= cfg_wdata;
        REG_RELOAD:     reload_r     <= cfg_wdata[RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  cpc_lane #(.CLK_HZ(TIMER_CLOCK_HZ)) u_red (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_ch.valid),
    .period(in_ch.red_period), .reload(reload_r),
    .low_freq(red_low_r), .high_freq(red_high_r),
    .out_vld(r_vld), .level(r_lvl)
  );

  cpc_lane #(.CLK_HZ(TIMER_CLOCK_HZ)) u_green (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_ch.valid),
    .period(in_ch.green_period), .reload(reload_r),
    .low_freq(green_low_r), .high_freq(green_high_r),
    .out_vld(g_vld), .level(g_lvl)
  );

  assign diff   = (r_lvl > g_lvl) ? r_lvl - g_lvl : g_lvl - r_lvl;
  assign decide = !((r_lvl > SAT_LEVEL) && (g_lvl > SAT_LEVEL)) && (diff > MARGIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= r_vld;
    end
    if (adv) begin
      red_level_r   <= r_lvl;
      green_level_r <= g_lvl;
      is_red_r      <= decide && (r_lvl > g_lvl);
      is_green_r    <= decide && !(r_lvl > g_lvl);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.red_level   = red_level_r;
  assign out_ch.green_level = green_level_r;
  assign out_ch.is_red      = is_red_r;
  assign out_ch.is_green    = is_green_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) r_vld == g_vld)
    else $error("color lanes out of step");
  a_one_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(is_red_r && is_green_r))
    else $error("both colors reported");
  a_red_margin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && is_red_r) |-> (red_level_r > green_level_r + 9'd20))
    else $error("red reported without margin");
  a_sat_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && red_level_r > 8'd250 && green_level_r > 8'd250)
      |-> (!is_red_r && !is_green_r))
    else $error("decision with both levels saturated");
endmodule

>>> rtl/cpc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module cpc_div #(
  parameter int NW = 36,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  logic          vld_r  [NW+1];
  logic [NW-1:0] nq_r   [NW+1];
  logic [DW-1:0] rem_r  [NW+1];
  logic [DW-1:0] den_r  [NW+1];
  logic [SW-1:0] side_r [NW+1];

  always_comb begin
    vld_r[0]  = in_vld;
    nq_r[0]   = in_num;
    rem_r[0]  = '0;
    den_r[0]  = in_den;
    side_r[0] = in_side;
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] nq_nxt;

    always_comb begin
      trial   = {rem_r[k], nq_r[k][NW-1]};
      ge      = trial >= {1'b0, den_r[k]};
      diff    = trial - {1'b0, den_r[k]};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      nq_nxt  = {nq_r[k][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (adv) begin
        nq_r[k+1]   <= nq_nxt;
        rem_r[k+1]  <= rem_nxt;
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[NW];
  assign out_quo  = nq_r[NW];
  assign out_side = side_r[NW];
endmodule

>>> rtl/cpc_lane.sv
// One color: period to microseconds to frequency to calibrated level.
`timescale 1ns / 1ps
module cpc_lane #(
  parameter int CLK_HZ = 42000000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic [cpc_pkg::PERIOD_W-1:0]   period,
  input  logic [cpc_pkg::RELOAD_W-1:0]   reload,
  input  logic [cpc_pkg::FREQ_CFG_W-1:0] low_freq,
  input  logic [cpc_pkg::FREQ_CFG_W-1:0] high_freq,
  output logic                           out_vld,
  output logic [cpc_pkg::LEVEL_W-1:0]    level
);
  import cpc_pkg::*;

  localparam logic [CLK_W-1:0] CLK_VAL = CLK_W'(CLK_HZ);

  logic                vld_a_r;
  logic [SCALED_W-1:0] num_a_r;
  logic                us_vld;
  logic [US_W-1:0]     us_quo;
  logic                us_zero;
  logic [US_W-1:0]     us_den;
  logic                f_vld;
  logic [CLK_W-1:0]    f_quo;
  logic                f_sat;
  logic [CLK_W-1:0]    freq;
  logic                vld_m_r;
  logic [SCALED_W-1:0] num_m_r;
  logic [FREQ_CFG_W-1:0] den_m_r;
  logic                neg_m_r;
  logic                eq_m_r;
  logic [CLK_W-1:0]    fh_mag;
  logic                f_above;
  logic [FREQ_CFG_W-1:0] lh_mag;
  logic                lv_vld;
  logic [SCALED_W-1:0] lv_quo;
  logic [1:0]          lv_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
    end
    if (adv) begin
      num_a_r <= SCALED_W'(period) * SCALED_W'(US_SCALE);
    end
  end

  cpc_div #(.NW(SCALED_W), .DW(RELOAD_W), .SW(1)) u_us_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(vld_a_r), .in_num(num_a_r), .in_den(reload), .in_side(1'b0),
    .out_vld(us_vld), .out_quo(us_quo), .out_side()
  );

  // A zero reload or a zero microsecond count saturates the frequency.
  assign us_zero = (reload == '0) || (us_quo == '0);
  assign us_den  = us_zero ? US_W'(1) : us_quo;

  cpc_div #(.NW(CLK_W), .DW(US_W), .SW(1)) u_freq_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(us_vld), .in_num(CLK_VAL), .in_den(us_den), .in_side(us_zero),
    .out_vld(f_vld), .out_quo(f_quo), .out_side(f_sat)
  );

  assign freq    = f_sat ? CLK_VAL : f_quo;
  assign f_above = freq > CLK_W'(high_freq);
  assign fh_mag  = f_above ? freq - CLK_W'(high_freq) : CLK_W'(high_freq) - freq;
  assign lh_mag  = (low_freq < high_freq) ? high_freq - low_freq : low_freq - high_freq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
    end else if (adv) begin
      vld_m_r <= f_vld;
    end
    if (adv) begin
      num_m_r <= SCALED_W'(fh_mag) * SCALED_W'(LEVEL_MAX);
      den_m_r <= lh_mag;
      neg_m_r <= f_above ^ (low_freq < high_freq);
      eq_m_r  <= low_freq == high_freq;
    end
  end

  cpc_div #(.NW(SCALED_W), .DW(FREQ_CFG_W), .SW(2)) u_lvl_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(vld_m_r), .in_num(num_m_r), .in_den(den_m_r), .in_side({neg_m_r, eq_m_r}),
    .out_vld(lv_vld), .out_quo(lv_quo), .out_side(lv_side)
  );

  // Equal bounds give 0; sign clear gives 255; else 255 - quotient, min 0.
  always_comb begin
    if (lv_side[0]) begin
      level = '0;
    end else if (!lv_side[1]) begin
      level = LEVEL_MAX;
    end else if (lv_quo > SCALED_W'(LEVEL_MAX)) begin
      level = '0;
    end else begin
      level = LEVEL_MAX - lv_quo[LEVEL_W-1:0];
    end
  end

  assign out_vld = lv_vld;
endmodule

>>> sim/tb_color_period_classifier_top.sv
// Self-checking testbench for the color period classifier top level.
`timescale 1ns / 1ps
module tb_color_period_classifier_top;
  import cpc_pkg::*;

  localparam longint CLK_HZ = 42000000;
  localparam int PIPE_LAT = 103;

  typedef struct packed {
    logic [PERIOD_W-1:0] red_period;
    logic [PERIOD_W-1:0] green_period;
  } period_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic               is_red;
    logic               is_green;
  } level_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cpc_in_if  in_ch ();
  cpc_out_if out_ch ();

  color_period_classifier_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Testbench copy of the calibration registers.
  longint red_lo, red_hi, green_lo, green_hi, reload;

  period_word_t pending_words[$];
  level_word_t  expected_levels[$];
  period_word_t drive_word;
  int           n_queued = 0;
  int           n_done = 0;
  int           errors = 0;
  int           cyc = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // Long window with no idling on either side.
  function automatic bit take_gap();
    if (cyc >= 1500 && cyc < 2500) return 1'b0;
    return $urandom_range(99) < 17;
  endfunction

  function automatic longint period_to_hz(longint period);
    longint us;
    us = (reload == 0) ? 0 : (period * 1000000) / reload;
    if (us == 0) return CLK_HZ;
    return CLK_HZ / us;
  endfunction

  function automatic longint hz_to_level(longint f, longint lo, longint hi);
    longint v;
    if (lo == hi) return 0;
    v = ((f - hi) * -255) / (lo - hi) + 255;
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic level_word_t classify(period_word_t w);
    level_word_t r;
    longint rl, gl, d;
    rl = hz_to_level(period_to_hz(w.red_period), red_lo, red_hi);
    gl = hz_to_level(period_to_hz(w.green_period), green_lo, green_hi);
    d = (rl > gl) ? rl - gl : gl - rl;
    r.red_level = rl[7:0];
    r.green_level = gl[7:0];
    r.is_red = 1'b0;
    r.is_green = 1'b0;
    if (!(rl > 250 && gl > 250) && d > 20) begin
      if (rl > gl) r.is_red = 1'b1;
      else r.is_green = 1'b1;
    end
    return r;
  endfunction

  // Driver: valid holds until the word is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.red_period <= '0;
      in_ch.green_period <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_levels.push_back(classify(drive_word));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && !take_gap()) begin
          drive_word = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.red_period <= drive_word.red_period;
          in_ch.green_period <= drive_word.green_period;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and in-order compare.
  always @(posedge clk) begin
    level_word_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !take_gap();
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.red_level, out_ch.green_level, out_ch.is_red, out_ch.is_green};
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected word r=%0d g=%0d is_red=%0b is_green=%0b", $time,
                   got.red_level, got.green_level, got.is_red, got.is_green);
          errors++;
        end else begin
          want = expected_levels.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected r=%0d g=%0d is_red=%0b is_green=%0b", $time,
                     want.red_level, want.green_level, want.is_red, want.is_green);
            $display("%0t:          actual   r=%0d g=%0d is_red=%0b is_green=%0b", $time,
                     got.red_level, got.green_level, got.is_red, got.is_green);
            errors++;
          end
        end
        n_done <= n_done + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_RED_LOW:    red_lo = value & 24'hFFFFFF;
      REG_RED_HIGH:   red_hi = value & 24'hFFFFFF;
      REG_GREEN_LOW:  green_lo = value & 24'hFFFFFF;
      REG_GREEN_HIGH: green_hi = value & 24'hFFFFFF;
      REG_RELOAD:     reload = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_calibration(longint rlo, longint rhi, longint glo, longint ghi,
                                 longint rel);
    write_reg(REG_RED_LOW, rlo);
    write_reg(REG_RED_HIGH, rhi);
    write_reg(REG_GREEN_LOW, glo);
    write_reg(REG_GREEN_HIGH, ghi);
    write_reg(REG_RELOAD, rel);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_word(int rp, int gp);
    period_word_t w;
    w.red_period = rp[15:0];
    w.green_period = gp[15:0];
    pending_words.push_back(w);
    n_queued++;
  endtask

  function automatic int pick_period();
    case ($urandom_range(2))
      0: return $urandom_range(65535);
      1: return $urandom_range(2000, 100);
      default: return $urandom_range(20);
    endcase
  endfunction

  task automatic queue_random(int n);
    repeat (n) queue_word(pick_period(), pick_period());
  endtask

  task automatic drain();
    while (n_done != n_queued) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  initial begin
    red_lo = 599; red_hi = 2441; green_lo = 566; green_hi = 1327; reload = 20000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, tiny and maximal periods, mid-range values near the
    // calibration points, ties and both-saturated pairs.
    queue_word(0, 0);
    queue_word(65535, 65535);
    queue_word(0, 65535);
    queue_word(65535, 0);
    queue_word(1, 1);
    queue_word(350, 1100);
    queue_word(1400, 740);
    queue_word(700, 700);
    queue_word(344, 633);
    queue_word(1402, 1484);
    queue_word(420, 900);
    queue_word(900, 420);
    queue_word(16'h5555, 16'hAAAA);
    queue_word(16'hAAAA, 16'h5555);
    queue_word(500, 520);
    queue_word(2, 65000);
    queue_random(140);
    drain();

    set_calibration(599, 2441, 566, 1327, 20000);
    queue_random(150);
    drain();

    // Extremes: full-scale bounds, equal bounds and the smallest reload.
    set_calibration(0, 24'hFFFFFF, 1000, 1000, 1);
    queue_word(0, 0);
    queue_word(65535, 65535);
    queue_random(120);
    drain();

    // Inverted bounds and the largest reload.
    set_calibration(24'hFFFFFF, 0, 5000, 100, 65535);
    queue_random(130);
    drain();

    // Zero reload saturates every frequency.
    set_calibration(24'h123456, 24'hABCDEF, 0, 24'hFFFFFF, 0);
    queue_random(40);
    drain();

    repeat (3) begin
      set_calibration($urandom_range(3000), $urandom_range(24'hFFFFFF),
                      $urandom_range(24'hFFFFFF), $urandom_range(3000),
                      $urandom_range(65535, 1));
      queue_random(125);
      drain();
    end

    if (errors == 0 && expected_levels.size() == 0)
      $display("tb_color_period_classifier_top: done, clean");
    else
      $display("tb_color_period_classifier_top: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_color_period_classifier_top: done, errors");
    $finish;
  end
endmodule
